[rtl/tcpq_pkg.sv]
// Shared types and constants for the two-class priority queue.
package tcpq_pkg;

  // Operation codes carried in a request word.
  typedef enum logic [1:0] {
    OP_APPEND   = 2'd0,
    OP_PRIORITY = 2'd1,
    OP_REMOVE   = 2'd2
  } op_t;

  // Status codes returned in every response word.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned OCC_W   = 5;
  localparam logic signed [VALUE_W-1:0] THRESHOLD_RESET = 32'sd59;

  // One request word.
  typedef struct packed {
    op_t                       op;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  // One response word.
  typedef struct packed {
    logic signed [VALUE_W-1:0] removed_value;
    logic                      removed_valid;
    status_t                   status;
    logic [OCC_W-1:0]          occupancy;
  } rsp_t;

  // Per-cell load selection; at most one member is set in a cycle.
  typedef struct packed {
    logic take_new;
    logic take_left;
    logic take_right;
  } cell_ctl_t;

endpackage

[rtl/tcpq_cell.sv]
// One storage cell of the queue chain with its threshold comparator.
module tcpq_cell (
  input  logic                               clk,
  input  logic signed [tcpq_pkg::VALUE_W-1:0] entry_left,
  input  logic signed [tcpq_pkg::VALUE_W-1:0] entry_right,
  input  logic signed [tcpq_pkg::VALUE_W-1:0] value,
  input  logic signed [tcpq_pkg::VALUE_W-1:0] threshold,
  input  tcpq_pkg::cell_ctl_t                 ctl,
  output logic signed [tcpq_pkg::VALUE_W-1:0] entry,
  output logic                               above
);
  import tcpq_pkg::*;

  // The held entry counts as a priority entry when strictly above the threshold.
  assign above = entry > threshold;

  // Load a new value, shift from a neighbor, or hold.
  always_ff @(posedge clk) begin
    if (ctl.take_new) begin
      entry <= value;
    end else if (ctl.take_left) begin
      entry <= entry_left;
    end else if (ctl.take_right) begin
      entry <= entry_right;
    end
  end

endmodule

[rtl/two_class_priority_queue.sv]
// Top level of the two-class priority queue: cell chain, count and response register.
//
//   channel  direction  handshake              word
//   req      in         req_valid / req_stall  tcpq_pkg::req_t
//   rsp      out        rsp_valid / rsp_stall  tcpq_pkg::rsp_t
//   cfg      in         cfg_wr_en              priority threshold, 32 bits signed
//
// Every request is handled in a single pass: all cells compare with the threshold and
// shift in parallel, so a new request word can be taken each cycle unless rsp is stalled.
// The response appears in the cycle after the request is taken.
// A stalled response holds the request side stalled until it is taken.
// Synchronous reset empties the queue and loads the threshold with 59; no clearing pass.
module two_class_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic signed [tcpq_pkg::VALUE_W-1:0] cfg_wr_data,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  tcpq_pkg::req_t                      req,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output tcpq_pkg::rsp_t                      rsp
);
  import tcpq_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic signed [VALUE_W-1:0] threshold;
  logic [CW-1:0]             count;
  logic [CW-1:0]             count_next;
  logic signed [VALUE_W-1:0] entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]    above;
  logic [QUEUE_DEPTH-1:0]    occ;
  logic [QUEUE_DEPTH-1:0]    run_before;
  cell_ctl_t                 ctl [QUEUE_DEPTH];
  logic                      accept;
  logic                      is_insert;
  logic                      is_remove;
  logic                      full;
  logic                      empty;
  logic                      do_insert;
  logic                      do_remove;
  logic                      pri;
  rsp_t                      rsp_next;

  // Request decode.
  assign accept    = req_valid && !req_stall;
  assign req_stall = rsp_valid && rsp_stall;
  assign is_insert = (req.op == OP_APPEND) || (req.op == OP_PRIORITY);
  assign is_remove = req.op == OP_REMOVE;
  assign full      = count == CW'(QUEUE_DEPTH);
  assign empty     = count == '0;
  assign do_insert = accept && is_insert && !full;
  assign do_remove = accept && is_remove && !empty;
  assign pri       = (req.op == OP_PRIORITY) && (req.value > threshold);

  // Cell chain with per-cell occupancy and leading-run detection.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_in;
    logic signed [VALUE_W-1:0] right_in;
    logic                      at_tail;

    assign occ[i] = count > CW'(i);

    if (i == 0) begin : g_head
      assign left_in       = '0;
      assign run_before[i] = 1'b1;
      assign at_tail       = !occ[i];
    end else begin : g_body
      assign left_in       = entry[i-1];
      assign run_before[i] = &(occ[i-1:0] & above[i-1:0]);
      assign at_tail       = !occ[i] && occ[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_in = '0;
    end else begin : g_mid
      assign right_in = entry[i+1];
    end

    // A priority insert lands right after the leading run; cells behind it shift up.
    always_comb begin
      ctl[i].take_new   = do_insert &&
                          (pri ? (run_before[i] && !(occ[i] && above[i])) : at_tail);
      ctl[i].take_left  = do_insert && pri && !run_before[i];
      ctl[i].take_right = do_remove;
    end

    tcpq_cell u_cell (
      .clk        (clk),
      .entry_left (left_in),
      .entry_right(right_in),
      .value      (req.value),
      .threshold  (threshold),
      .ctl        (ctl[i]),
      .entry      (entry[i]),
      .above      (above[i])
    );
  end

  // Next entry count and response word.
  always_comb begin
    count_next             = count;
    rsp_next.removed_value = '0;
    rsp_next.removed_valid = 1'b0;
    rsp_next.status        = ST_OK;
    case (req.op)
      OP_APPEND, OP_PRIORITY: begin
        if (full) begin
          rsp_next.status = ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          rsp_next.status = ST_EMPTY;
        end else begin
          count_next             = count - CW'(1);
          rsp_next.removed_value = entry[0];
          rsp_next.removed_valid = 1'b1;
        end
      end
      default: begin
        count_next = count;
      end
    endcase
    rsp_next.occupancy = OCC_W'(count_next);
  end

  // Threshold, count and response registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        threshold <= cfg_wr_data;
      end
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
    if (accept) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTH
  // The count never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  // A popped value always comes with an ok status.
  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.removed_valid) |-> (rsp.status == ST_OK))
    else $error("popped value with error status");

  // A successful insert grows the queue by exactly one.
  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    do_insert |=> (count == $past(count) + CW'(1)))
    else $error("insert did not advance the count");

  // A response reports the count the queue holds afterward.
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (rsp_valid && (rsp.occupancy == OCC_W'(count))))
    else $error("response occupancy disagrees with count");

  // At most one load source is chosen for the head cell.
  a_head_ctl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl[0].take_new, ctl[0].take_left, ctl[0].take_right}))
    else $error("head cell has conflicting load selects");
`endif

endmodule
